[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Field widths, operation and status codes, sequencer states and the memory
// control bundle.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF   = 1024;

  localparam int FUNC_W      = 3;
  localparam int DATA_W      = 64;
  localparam int STAT_W      = 2;
  localparam int COUNT_W     = 11;

  localparam int IN_TDATA_W  = 72;   // func + value = 67 bits, padded to bytes
  localparam int OUT_TDATA_W = 80;   // status + data + count = 77 bits, padded

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_CLEAR      = 3'd6
  } deq_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } deq_state_t;

  // Entry memory strobes for one cycle
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[design/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed 64-bit values
// Ring buffer in a single-port-write, single-port-read memory with front and
// back positions and an entry count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: func selects push front/back, pop
//   front/back, peek front/back or clear; value is the word to push. Each
//   accepted request yields exactly one transfer on the out_ stream with
//   status (ok, empty, full), the popped or peeked data (zero otherwise) and
//   the entry count after the request.
//   Results: push, clear, refused or unused requests give their result in
//   the cycle after acceptance, and a new request can be taken every cycle
//   while the output register is free. Pops and peeks read the entry memory
//   (registered read), so their result passes the read data register and then
//   the output register; no new request is taken while the read is pending.
//   A result waits in the output register while out_tready is low; in_tready
//   stays high only if that register frees in the same cycle.
//   Reset clears the positions, the count and the output valid; stored words
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata,   // func[2:0], value[66:3]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata   // status[1:0], data[65:2],
                                                      // count[76:66]
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;

  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mem_ctl    (mem_ctl),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  // Read data arrives in the next cycle and the result is valid the cycle after
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.re |-> ##2 out_tvalid)
    else $error("read request did not produce a result");

  // No request is taken while a read is in flight
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.re |=> !in_tready)
    else $error("request accepted during entry read");

  // One request touches the memory on one port only
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("write and read issued together");

endmodule

[design/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram: entry storage of the double-ended queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  deq_pkg::mem_ctl_t         mem_ctl,
  input  logic [AW-1:0]             waddr,
  input  logic [deq_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [deq_pkg::DATA_W-1:0] rdata
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the pushed value
  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the addressed entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl: pointer, count and result control of the double-ended queue
// Decodes each request, updates front/back positions and the entry count,
// drives the entry memory and holds the result register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output deq_pkg::mem_ctl_t              mem_ctl,
  output logic [AW-1:0]                  waddr,
  output logic [deq_pkg::DATA_W-1:0]     wdata,
  output logic [AW-1:0]                  raddr,
  input  logic [deq_pkg::DATA_W-1:0]     rdata
);
  import deq_pkg::*;

  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_POS : p - AW'(1);
  endfunction

  deq_state_t        state_r, state_nxt;
  logic [AW-1:0]     front_r, front_nxt;
  logic [AW-1:0]     back_r, back_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  deq_status_t       out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [CW-1:0]     out_cnt_r, out_cnt_nxt;

  deq_func_t         func;
  logic              accept;
  logic              full;
  logic              empty;
  deq_status_t       status;

  assign func   = deq_func_t'(in_tdata[FUNC_W-1:0]);
  assign wdata  = in_tdata[FUNC_W +: DATA_W];
  assign full   = (cnt_r == FULL_CNT);
  assign empty  = (cnt_r == '0);

  // Take a request only when idle and the result register frees this cycle
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // Decode the request, update positions, steer the memory, load the result
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;
    mem_ctl        = '0;
    waddr          = back_r;
    raddr          = front_r;
    status         = ST_OK;

    case (func)
      FN_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          waddr      = ring_prev(front_r);
          mem_ctl.we = accept;
          front_nxt  = ring_prev(front_r);
          cnt_nxt    = cnt_r + CW'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          waddr      = back_r;
          mem_ctl.we = accept;
          back_nxt   = ring_next(back_r);
          cnt_nxt    = cnt_r + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          raddr      = front_r;
          mem_ctl.re = accept;
          front_nxt  = ring_next(front_r);
          cnt_nxt    = cnt_r - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          raddr      = ring_prev(back_r);
          mem_ctl.re = accept;
          back_nxt   = ring_prev(back_r);
          cnt_nxt    = cnt_r - CW'(1);
        end
      end
      FN_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          raddr      = front_r;
          mem_ctl.re = accept;
        end
      end
      FN_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          raddr      = ring_prev(back_r);
          mem_ctl.re = accept;
        end
      end
      FN_CLEAR: begin
        front_nxt = '0;
        back_nxt  = '0;
        cnt_nxt   = '0;
      end
      default: begin
        // unused code: no operation
      end
    endcase

    case (state_r)
      S_IDLE: begin
        if (!accept) begin
          front_nxt = front_r;
          back_nxt  = back_r;
          cnt_nxt   = cnt_r;
        end else begin
          out_status_nxt = status;
          out_cnt_nxt    = cnt_nxt;
          out_data_nxt   = '0;
          if (mem_ctl.re) begin
            // wait in S_READ for the entry read
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        front_nxt     = front_r;
        back_nxt      = back_r;
        cnt_nxt       = cnt_r;
        out_data_nxt  = rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (OUT_TDATA_W - STAT_W - DATA_W - COUNT_W)'(0),
    COUNT_W'(out_cnt_r),
    out_data_r,
    out_status_r
  };

endmodule

[tb/sv/tb_double_ended_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: self-checking bench for the double-ended queue
// Drives requests on the in_ stream and checks every result on the out_ stream
// against a local ring-buffer predictor. The bench covers the empty and full
// queue, both ends with wraparound, clear, the unused operation code and a
// long random run. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] VAL_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ALT   = 64'hAAAA_5555_AAAA_5555;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } deq_resp_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_RARE_STALL,
    RX_HEAVY_STALL
  } rx_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // func[2:0], value[66:3]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // status[1:0], data[65:2], count[76:66]

  // Predictor state: a private copy of the ring
  logic [DATA_W-1:0] mdl_entries [DEPTH];
  int                mdl_front = 0;
  int                mdl_back  = 0;
  int                mdl_count = 0;

  deq_resp_t pending_resps[$];
  int        mismatch_cnt = 0;
  int        cycle_cnt    = 0;
  int        burst_left   = 0;
  rx_mode_t  rx_mode      = RX_ALWAYS;
  int        rx_left      = 0;

  double_ended_queue_top #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int ring_prev(int pos);
    return (pos == 0) ? DEPTH - 1 : pos - 1;
  endfunction

  function automatic int ring_next(int pos);
    return (pos + 1 >= DEPTH) ? 0 : pos + 1;
  endfunction

  // Apply one request to the local ring and return the response it gives
  function automatic deq_resp_t predict_response(logic [FUNC_W-1:0] fn,
                                                 logic [DATA_W-1:0] val);
    deq_resp_t r;
    r.status = ST_OK;
    r.data   = '0;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (mdl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (fn == FN_PUSH_FRONT) begin
          mdl_front = ring_prev(mdl_front);
          mdl_entries[mdl_front] = val;
          mdl_count++;
        end else begin
          mdl_entries[mdl_back] = val;
          mdl_back = ring_next(mdl_back);
          mdl_count++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
        end else if (fn == FN_POP_FRONT) begin
          r.data = mdl_entries[mdl_front];
          mdl_front = ring_next(mdl_front);
          mdl_count--;
        end else if (fn == FN_POP_BACK) begin
          mdl_back = ring_prev(mdl_back);
          r.data = mdl_entries[mdl_back];
          mdl_count--;
        end else if (fn == FN_PEEK_FRONT) begin
          r.data = mdl_entries[mdl_front];
        end else begin
          r.data = mdl_entries[ring_prev(mdl_back)];
        end
      end
      FN_CLEAR: begin
        mdl_front = 0;
        mdl_back  = 0;
        mdl_count = 0;
      end
      default: ;
    endcase
    r.count = COUNT_W'(mdl_count);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return VAL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Send one request; open a new burst after a random gap when the old one ends
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - FUNC_W - DATA_W){1'b0}}, val, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_resps.insert(pending_resps.size(), predict_response(fn, val));
  endtask

  // Receiver stall pattern: switch to a random mode when the current one runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'(2'($urandom_range(0, 3)));
      rx_left <= $urandom_range(4, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:     out_tready <= 1'b1;
      RX_COIN:       out_tready <= ($urandom_range(0, 1) == 1);
      RX_RARE_STALL: out_tready <= ($urandom_range(0, 7) != 0);
      default:       out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each result transfer with the oldest expected response
  always @(posedge clk) begin
    deq_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resps.size() == 0) begin
        report_mismatch("unexpected result data", out_tdata[65:2], '0);
      end else begin
        want = pending_resps[0];
        pending_resps.delete(0);
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", DATA_W'(out_tdata[1:0]), DATA_W'(want.status));
        if (out_tdata[65:2] !== want.data)
          report_mismatch("data", out_tdata[65:2], want.data);
        if (out_tdata[76:66] !== want.count)
          report_mismatch("count", DATA_W'(out_tdata[76:66]), DATA_W'(want.count));
      end
    end
  end

  // Pop, peek, clear and the unused code on an empty queue
  task automatic test_empty_queue();
    send_request(FN_POP_FRONT, VAL_ONES);
    send_request(FN_POP_BACK, VAL_MAX);
    send_request(FN_PEEK_FRONT, VAL_MIN);
    send_request(FN_PEEK_BACK, '0);
    send_request(FN_UNUSED, VAL_ALT);
    send_request(FN_CLEAR, VAL_ONES);
  endtask

  // Both ends with extreme values; push front from position zero wraps
  task automatic test_both_ends();
    send_request(FN_PUSH_FRONT, VAL_MIN);
    send_request(FN_PUSH_BACK, VAL_MAX);
    send_request(FN_PUSH_FRONT, VAL_ONES);
    send_request(FN_PUSH_BACK, '0);
    send_request(FN_PUSH_BACK, VAL_ALT);
    send_request(FN_UNUSED, VAL_MAX);
    send_request(FN_PEEK_FRONT, '0);
    send_request(FN_PEEK_BACK, '0);
    send_request(FN_POP_FRONT, '0);
    send_request(FN_POP_BACK, '0);
    send_request(FN_POP_FRONT, '0);
    send_request(FN_POP_BACK, '0);
    send_request(FN_POP_BACK, '0);
    send_request(FN_POP_FRONT, '0);
  endtask

  // Clear drops stored entries in one step
  task automatic test_clear();
    send_request(FN_PUSH_BACK, ~VAL_ALT);
    send_request(FN_PUSH_FRONT, VAL_MAX);
    send_request(FN_CLEAR, '0);
    send_request(FN_PEEK_BACK, '0);
    send_request(FN_PUSH_BACK, VAL_MIN);
    send_request(FN_PEEK_FRONT, '0);
    send_request(FN_CLEAR, '0);
  endtask

  // Fill to capacity, refuse pushes at both ends, then free one slot and refill it
  task automatic test_full_queue();
    while (mdl_count < DEPTH) send_request(FN_PUSH_BACK, random_value());
    send_request(FN_PUSH_FRONT, VAL_MAX);
    send_request(FN_PUSH_BACK, VAL_MIN);
    send_request(FN_PEEK_FRONT, '0);
    send_request(FN_PEEK_BACK, '0);
    send_request(FN_POP_BACK, '0);
    send_request(FN_PUSH_FRONT, VAL_ALT);
    send_request(FN_PUSH_BACK, VAL_ONES);
    send_request(FN_POP_FRONT, '0);
    send_request(FN_PEEK_FRONT, '0);
    send_request(FN_CLEAR, '0);
  endtask

  // Random mix in phases that lean toward filling or draining
  task automatic test_random_traffic();
    int push_pct;
    int pick;
    logic [FUNC_W-1:0] fn;
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) push_pct = $urandom_range(10, 90);
      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        fn = FN_UNUSED;
      end else if (pick < 3) begin
        fn = FN_CLEAR;
      end else if (pick < 3 + push_pct) begin
        fn = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      end else begin
        case ($urandom_range(0, 3))
          0:       fn = FN_POP_FRONT;
          1:       fn = FN_POP_BACK;
          2:       fn = FN_PEEK_FRONT;
          default: fn = FN_PEEK_BACK;
        endcase
      end
      send_request(fn, random_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_both_ends();
    test_clear();
    test_full_queue();
    test_random_traffic();
    in_tvalid <= 1'b0;
    // Drain outstanding responses, then watch for strays
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/double_ended_queue_top.sv
tb/sv/tb_double_ended_queue_top.sv
